// ===== design/itba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itba_pkg - shared types and constants for the integer-to-text formatter
// Widths, radix limits, ASCII codes, sequencer states and the digit encoder.
// ----------------------------------------------------------------------------
package itba_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W       = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] MINUS_CODE = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic quo_zero;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < DEC_DIGITS)
        begin
            r = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            r = ASCII_A + CHAR_W'(d - DEC_DIGITS);
        end
        return r;
    endfunction

endpackage

// ===== design/itba_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itba_div - bit-serial restoring divider by the radix
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module itba_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [itba_pkg::VALUE_WIDTH-1:0]    dividend,
    input  logic [itba_pkg::RADIX_W-1:0]        radix,
    output logic [itba_pkg::VALUE_WIDTH-1:0]    quotient,
    output logic [itba_pkg::RADIX_W-1:0]        remainder,
    output itba_pkg::div_stat_t                 stat
);
    import itba_pkg::*;

    localparam logic [IDX_W-1:0] BIT_LAST = IDX_W'(VALUE_WIDTH - 1);

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [IDX_W-1:0]       bit_cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [RADIX_W:0]       rem_sh;
    logic [RADIX_W:0]       rem_sub;
    logic                   ge;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [RADIX_W-1:0]     rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        rem_sub  = rem_sh - {1'b0, radix};
        ge       = (rem_sh >= {1'b0, radix});
        rem_next = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
        quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BIT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient      = quo_reg;
    assign remainder     = rem_reg;
    assign stat.done     = done_reg;
    assign stat.quo_zero = (quo_reg == '0);

endmodule

// ===== design/integer_to_base_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_base_ascii - signed integer to ASCII text in base 2 to 36
// Sequencer, digit stack, radix register and character output word.
// ----------------------------------------------------------------------------
// One signed VALUE_WIDTH-bit value is taken while the block is idle and comes
// out as ASCII words, most significant first, '-' leading for negatives, with
// last_char set on the final word. Digits come from one shared bit-serial
// divider, one division per digit; the block divides out all digits of a
// number first and then sends its characters, waiting while the output stalls,
// and it takes no new value until the last character has been loaded.
// in_stall is high from acceptance until the last word sits in the output
// register. The radix register resets to 10; writes outside 2..36 are ignored.
// cfg_ready is high only while the block is idle and no value is offered, so
// the radix never changes under a number in progress.
// ----------------------------------------------------------------------------
module integer_to_base_ascii (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [itba_pkg::RADIX_W-1:0]            cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [itba_pkg::VALUE_WIDTH-1:0] value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [itba_pkg::CHAR_W-1:0]             char_code,
    output logic                                    last_char
);
    import itba_pkg::*;

    state_t                 state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   minus_pend_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    logic [VALUE_WIDTH-1:0] value_u;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic                   accept;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic                   dig_we;
    logic                   out_load;
    logic [IDX_W-1:0]       rd_idx;
    logic [CHAR_W-1:0]      char_sel;
    logic                   last_sel;

    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_W-1:0]     remainder;
    div_stat_t              div_stat;

    assign value_u = value;
    assign neg     = value_u[VALUE_WIDTH-1];
    assign mag_in  = neg ? VALUE_WIDTH'(~value_u + 1'b1) : value_u;
    assign rd_idx  = IDX_W'(cnt_reg - 1'b1);

    itba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .radix     (radix_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done && div_stat.quo_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && !minus_pend_reg && (cnt_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        accept    = 1'b0;
        div_start = 1'b0;
        dividend  = quotient;
        dig_we    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                accept    = in_valid;
                div_start = in_valid;
                dividend  = mag_in;
            end
            ST_DIVIDE:
            begin
                dig_we    = div_stat.done;
                div_start = div_stat.done && !div_stat.quo_zero;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (minus_pend_reg)
        begin
            char_sel = MINUS_CODE;
            last_sel = 1'b0;
        end
        else
        begin
            char_sel = digit_char(digit_mem[rd_idx]);
            last_sel = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            radix_reg      <= RADIX_RESET;
            minus_pend_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && (cfg_data >= RADIX_MIN) && (cfg_data <= RADIX_MAX))
            begin
                radix_reg <= cfg_data;
            end
            if (accept)
            begin
                minus_pend_reg <= neg;
                cnt_reg        <= '0;
            end
            else if (dig_we)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (out_load)
            begin
                if (minus_pend_reg)
                begin
                    minus_pend_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= remainder;
        end
        if (out_load)
        begin
            char_reg <= char_sel;
            last_reg <= last_sel;
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule
